[src/fsmw_pkg.sv]
// Shared types and constants for the fair-share max-weight scheduler.
// Used by fsmw_muldiv, the scheduler and its testbench; depends on nothing else.
package fsmw_pkg;

  localparam int CNT_W   = 7;   // per-tick packet counts, up to 127
  localparam int MEAN_W  = 24;  // running-mean delay, 16.8 fixed point
  localparam int COUNT_W = 32;  // per-queue served counter
  localparam int NUM_W   = 57;  // numerator of the mean update
  localparam int MASK_W  = 20;
  localparam int CAPI_W  = 6;
  localparam int QIDX_W  = 5;
  localparam int DLY_W   = 16;

  typedef struct packed {
    logic [MASK_W-1:0] arrival_mask;
    logic [CAPI_W-1:0] capacity;
  } in_t;

  typedef struct packed {
    logic              served_valid;
    logic [QIDX_W-1:0] queue_index;
    logic [DLY_W-1:0]  packet_delay;
    logic              phase;
    logic              last;
  } out_t;

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_MUL  = 3'b010,
    MD_DIV  = 3'b100
  } md_state_t;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_ENQ   = 10'b0000000010,
    S_SHARE = 10'b0000000100,
    S_FAIR  = 10'b0000001000,
    S_SCAN0 = 10'b0000010000,
    S_SCAN  = 10'b0000100000,
    S_RD    = 10'b0001000000,
    S_DLY   = 10'b0010000000,
    S_MDS   = 10'b0100000000,
    S_MD    = 10'b1000000000
  } seq_state_t;

  typedef enum logic {
    PH_FAIR = 1'b0,
    PH_MAXW = 1'b1
  } phase_t;

endpackage

[src/fsmw_store.sv]
// Arrival-tick store: one single-port-write, registered-read memory
// holding every queue's FIFO entries. Depends on nothing else.
module fsmw_store #(
  parameter int DEPTH  = 20480,
  parameter int ADDR_W = 15,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/fsmw_muldiv.sv]
// Shared mean-update unit: (a*b + addend) / divisor, saturated to 24 bits.
// Shift-add multiply, one bit a cycle, then restoring divide. Uses fsmw_pkg.
module fsmw_muldiv (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [fsmw_pkg::COUNT_W-1:0] mul_a,
  input  logic [fsmw_pkg::MEAN_W-1:0]  mul_b,
  input  logic [fsmw_pkg::NUM_W-1:0]   addend,
  input  logic [fsmw_pkg::COUNT_W-1:0] divisor,
  output logic                         done,
  output logic [fsmw_pkg::MEAN_W-1:0]  quot_sat
);

  localparam int NW = fsmw_pkg::NUM_W;
  localparam int DW = fsmw_pkg::COUNT_W;
  localparam int MW = fsmw_pkg::MEAN_W;

  fsmw_pkg::md_state_t state_r;
  logic [5:0]    cnt_r;
  logic [NW-1:0] mcand_r;
  logic [MW-1:0] mplier_r;
  logic [NW-1:0] acc_r;
  logic [DW:0]   rem_r;
  logic [DW-1:0] div_r;
  logic          done_r;
  logic [DW:0]   rem_sh;
  logic          q_bit;

  assign rem_sh = {rem_r[DW-1:0], acc_r[NW-1]};
  assign q_bit  = (rem_sh >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsmw_pkg::MD_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        fsmw_pkg::MD_IDLE: begin
          if (start) begin
            // seed the accumulator with the addend to save a final add
            acc_r    <= addend;
            mcand_r  <= NW'(mul_a);
            mplier_r <= mul_b;
            div_r    <= divisor;
            cnt_r    <= '0;
            done_r   <= 1'b0;
            state_r  <= fsmw_pkg::MD_MUL;
          end
        end
        fsmw_pkg::MD_MUL: begin
          if (mplier_r[0]) begin
            acc_r <= acc_r + mcand_r;
          end
          mcand_r  <= {mcand_r[NW-2:0], 1'b0};
          mplier_r <= mplier_r >> 1;
          if (cnt_r == 6'(MW - 1)) begin
            cnt_r   <= '0;
            rem_r   <= '0;
            state_r <= fsmw_pkg::MD_DIV;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        fsmw_pkg::MD_DIV: begin
          // quotient bits shift into the numerator register
          rem_r <= q_bit ? (rem_sh - {1'b0, div_r}) : rem_sh;
          acc_r <= {acc_r[NW-2:0], q_bit};
          if (cnt_r == 6'(NW - 1)) begin
            done_r  <= 1'b1;
            state_r <= fsmw_pkg::MD_IDLE;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        default: state_r <= fsmw_pkg::MD_IDLE;
      endcase
    end
  end

  assign done     = done_r;
  assign quot_sat = (|acc_r[NW-1:MW]) ? {MW{1'b1}} : acc_r[MW-1:0];

endmodule

[src/fair_share_max_weight_scheduler.sv]
// Each tick runs an enqueue walk, the share division, a fair-share walk, and
// accept and finish; every served packet passes through the multiply and
// divide of the shared mean-update unit, and every max-weight grant is
// preceded by a queue scan. One tick at a time: in_stall is high until the
// tick's last result is loaded. Reset clears per-queue state at once; the
// arrival store needs no clearing.
module fair_share_max_weight_scheduler #(
  parameter int NUM_QUEUES   = 20,
  parameter int QUEUE_DEPTH  = 1024,
  parameter int MAX_CAPACITY = 60,
  parameter int TIME_BITS    = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  fsmw_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output fsmw_pkg::out_t  out_data
);

  localparam int QW     = $clog2(NUM_QUEUES);
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_D  = NUM_QUEUES * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(MEM_D);
  localparam int TOT_W  = $clog2(MEM_D + 1);
  localparam int CW     = fsmw_pkg::CNT_W;
  localparam int MW     = fsmw_pkg::MEAN_W;
  localparam int KW     = fsmw_pkg::COUNT_W;
  localparam int NW     = fsmw_pkg::NUM_W;

  fsmw_pkg::seq_state_t state_r;
  logic [PTR_W-1:0] head_r [NUM_QUEUES];
  logic [OCC_W-1:0] occ_r  [NUM_QUEUES];
  logic [KW-1:0]    cnt_r  [NUM_QUEUES];
  logic [MW-1:0]    mean_r [NUM_QUEUES];

  logic [QW-1:0]    q_r, cur_q_r, best_r;
  logic [OCC_W-1:0] best_occ_r;
  logic [MW-1:0]    best_mean_r;
  logic [fsmw_pkg::MASK_W-1:0] mask_r;
  logic [CW-1:0]    cap_r, n_r, rem_r, share_r, j_r, served_r;
  logic [TOT_W-1:0] total_r;
  logic [TIME_BITS-1:0] tick_r, delay_r;
  fsmw_pkg::phase_t phase_r;
  fsmw_pkg::out_t   pend_r, out_r;
  logic             pend_v_r, out_valid_r;

  // store
  logic              st_wr, st_rd;
  logic [ADDR_W-1:0] st_waddr, st_raddr;
  logic [TIME_BITS-1:0] st_rdata;

  // mean-update unit
  logic          md_start, md_done;
  logic [MW-1:0] md_quot;

  logic             q_last, arr_bit, do_arr, out_free, better;
  logic [OCC_W-1:0] occ_q, occ_new;
  logic [OCC_W:0]   slot_sum;
  logic [PTR_W-1:0] slot;
  logic [TOT_W-1:0] total_nxt;
  logic [CW-1:0]    cap_in;
  logic [QW-1:0]    w_q;
  logic [OCC_W-1:0] w_occ;
  logic [MW-1:0]    w_mean;
  logic [31:0]      dly_ext;

  assign q_last  = (q_r == QW'(NUM_QUEUES - 1));
  assign arr_bit = (32'(q_r) < 32'(fsmw_pkg::MASK_W)) ? mask_r[5'(q_r)] : 1'b0;
  assign occ_q   = occ_r[q_r];
  assign do_arr  = arr_bit && (occ_q != OCC_W'(QUEUE_DEPTH));
  assign occ_new = occ_q + OCC_W'(do_arr);
  assign slot_sum = (OCC_W+1)'(head_r[q_r]) + (OCC_W+1)'(occ_q);
  assign slot = (32'(slot_sum) >= 32'(QUEUE_DEPTH)) ?
                PTR_W'(slot_sum - (OCC_W+1)'(QUEUE_DEPTH)) : PTR_W'(slot_sum);
  assign total_nxt = total_r + TOT_W'(occ_new);
  assign cap_in = CW'(in_data.capacity);
  assign out_free = !out_valid_r || !out_stall;

  assign better = (occ_q > best_occ_r) ||
                  ((occ_q == best_occ_r) && (mean_r[q_r] > best_mean_r));
  assign w_q    = better ? q_r : best_r;
  assign w_occ  = better ? occ_q : best_occ_r;
  assign w_mean = better ? mean_r[q_r] : best_mean_r;

  assign st_wr    = (state_r == fsmw_pkg::S_ENQ) && do_arr;
  assign st_waddr = ADDR_W'(q_r) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);
  assign st_rd    = (state_r == fsmw_pkg::S_RD);
  assign st_raddr = ADDR_W'(cur_q_r) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_r[cur_q_r]);
  assign md_start = (state_r == fsmw_pkg::S_MDS);
  assign dly_ext  = 32'(delay_r);

  fsmw_store #(
    .DEPTH  (MEM_D),
    .ADDR_W (ADDR_W),
    .DATA_W (TIME_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr),
    .wr_addr (st_waddr),
    .wr_data (tick_r),
    .rd_en   (st_rd),
    .rd_addr (st_raddr),
    .rd_data (st_rdata)
  );

  fsmw_muldiv u_muldiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (md_start),
    .mul_a    (cnt_r[cur_q_r] - KW'(1)),
    .mul_b    (mean_r[cur_q_r]),
    .addend   (NW'({dly_ext, 8'd0})),
    .divisor  (cnt_r[cur_q_r]),
    .done     (md_done),
    .quot_sat (md_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fsmw_pkg::S_IDLE;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      tick_r      <= '0;
      served_r    <= '0;
      n_r         <= '0;
      cur_q_r     <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i] <= '0;
        occ_r[i]  <= '0;
        cnt_r[i]  <= '0;
        mean_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        fsmw_pkg::S_IDLE: begin
          if (in_valid) begin
            mask_r   <= in_data.arrival_mask;
            cap_r    <= (32'(cap_in) > MAX_CAPACITY) ? CW'(MAX_CAPACITY) : cap_in;
            q_r      <= '0;
            total_r  <= '0;
            served_r <= '0;
            n_r      <= '0;
            state_r  <= fsmw_pkg::S_ENQ;
          end
        end
        fsmw_pkg::S_ENQ: begin
          occ_r[q_r] <= occ_new;
          total_r    <= total_nxt;
          if (q_last) begin
            if (32'(total_nxt) < 32'(cap_r)) begin
              n_r   <= CW'(total_nxt);
              rem_r <= CW'(total_nxt);
            end else begin
              n_r   <= cap_r;
              rem_r <= cap_r;
            end
            share_r <= '0;
            state_r <= fsmw_pkg::S_SHARE;
          end else begin
            q_r <= q_r + QW'(1);
          end
        end
        fsmw_pkg::S_SHARE: begin
          // divide by the queue count through repeated subtraction
          if (32'(rem_r) >= NUM_QUEUES) begin
            rem_r   <= rem_r - CW'(NUM_QUEUES);
            share_r <= share_r + CW'(1);
          end else begin
            q_r     <= '0;
            j_r     <= '0;
            state_r <= fsmw_pkg::S_FAIR;
          end
        end
        fsmw_pkg::S_FAIR: begin
          if ((j_r < share_r) && (occ_q != '0)) begin
            cur_q_r <= q_r;
            phase_r <= fsmw_pkg::PH_FAIR;
            state_r <= fsmw_pkg::S_RD;
          end else if (q_last) begin
            state_r <= fsmw_pkg::S_SCAN0;
          end else begin
            q_r <= q_r + QW'(1);
            j_r <= '0;
          end
        end
        fsmw_pkg::S_SCAN0: begin
          if (served_r >= n_r) begin
            // finish the tick: flag the held result as last, or report idle
            if (out_free) begin
              out_r       <= pend_v_r ?
                             fsmw_pkg::out_t'{pend_r.served_valid, pend_r.queue_index,
                                              pend_r.packet_delay, pend_r.phase, 1'b1}
                           : fsmw_pkg::out_t'{1'b0, '0, '0, 1'b0, 1'b1};
              out_valid_r <= 1'b1;
              pend_v_r    <= 1'b0;
              tick_r      <= tick_r + TIME_BITS'(1);
              state_r     <= fsmw_pkg::S_IDLE;
            end
          end else begin
            best_r      <= '0;
            best_occ_r  <= occ_r[0];
            best_mean_r <= mean_r[0];
            q_r         <= QW'(1);
            state_r     <= fsmw_pkg::S_SCAN;
          end
        end
        fsmw_pkg::S_SCAN: begin
          best_r      <= w_q;
          best_occ_r  <= w_occ;
          best_mean_r <= w_mean;
          if (q_last) begin
            if (w_occ == '0) begin
              n_r     <= served_r;
              state_r <= fsmw_pkg::S_SCAN0;
            end else begin
              cur_q_r <= w_q;
              phase_r <= fsmw_pkg::PH_MAXW;
              state_r <= fsmw_pkg::S_RD;
            end
          end else begin
            q_r <= q_r + QW'(1);
          end
        end
        fsmw_pkg::S_RD: begin
          head_r[cur_q_r] <= (head_r[cur_q_r] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                             head_r[cur_q_r] + PTR_W'(1);
          occ_r[cur_q_r]  <= occ_r[cur_q_r] - OCC_W'(1);
          if (cnt_r[cur_q_r] != {KW{1'b1}}) begin
            cnt_r[cur_q_r] <= cnt_r[cur_q_r] + KW'(1);
          end
          state_r <= fsmw_pkg::S_DLY;
        end
        fsmw_pkg::S_DLY: begin
          delay_r <= tick_r - st_rdata;
          state_r <= fsmw_pkg::S_MDS;
        end
        fsmw_pkg::S_MDS: begin
          state_r <= fsmw_pkg::S_MD;
        end
        fsmw_pkg::S_MD: begin
          // drain the held result while the mean update runs
          if (pend_v_r && out_free) begin
            out_r       <= pend_r;
            out_valid_r <= 1'b1;
            pend_v_r    <= 1'b0;
          end
          if (md_done && !pend_v_r) begin
            mean_r[cur_q_r] <= md_quot;
            pend_r   <= '{1'b1, fsmw_pkg::QIDX_W'(cur_q_r), dly_ext[15:0],
                          phase_r, 1'b0};
            pend_v_r <= 1'b1;
            served_r <= served_r + CW'(1);
            if (phase_r == fsmw_pkg::PH_FAIR) begin
              j_r     <= j_r + CW'(1);
              state_r <= fsmw_pkg::S_FAIR;
            end else begin
              state_r <= fsmw_pkg::S_SCAN0;
            end
          end
        end
        default: state_r <= fsmw_pkg::S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != fsmw_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fsmw_pkg::S_IDLE) |-> !pend_v_r)
    else $error("held result left over between ticks");

  a_served_le_n: assert property (@(posedge clk) disable iff (!rst_n)
    served_r <= n_r)
    else $error("more grants than capacity allows");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(occ_r[cur_q_r]) <= QUEUE_DEPTH)
    else $error("queue occupancy beyond depth");

  a_rd_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fsmw_pkg::S_RD) |-> (occ_r[cur_q_r] != '0))
    else $error("grant to an empty queue");

endmodule

[dv/tb_fair_share_max_weight_scheduler.sv]
// Self-checking testbench for the fair-share max-weight scheduler.
// Depends on fsmw_pkg and fair_share_max_weight_scheduler from src.
`timescale 1ns / 100ps

module tb_fair_share_max_weight_scheduler;

  localparam int NQ       = 20;
  localparam int QDEPTH   = 1024;
  localparam int MAXCAP   = 60;
  localparam int IDLE_LIM = 20000;
  localparam int RAND_TICKS = 360;
  localparam int FILL_TICKS = 30;
  localparam int HOLD_LEN   = 3000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  fsmw_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  fsmw_pkg::out_t out_data;

  always #5 clk = ~clk;

  fair_share_max_weight_scheduler dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Scheduler shadow state
  logic [15:0] arr_tick [NQ][QDEPTH];
  int unsigned q_head [NQ];
  int unsigned q_occ [NQ];
  int unsigned q_served [NQ];
  int unsigned q_mean [NQ];
  logic [15:0] now_tick;

  fsmw_pkg::out_t grant_q[$];
  int   mismatches = 0;
  int   idle_cycles = 0;
  int   hold_cycles = 0;
  bit   hold_req = 1'b0;
  bit   hold_taken = 1'b0;

  function automatic logic [15:0] serve_packet(int q);
    logic [15:0] dly;
    longint unsigned num, m;
    dly = now_tick - arr_tick[q][q_head[q]];
    q_head[q] = (q_head[q] + 1) % QDEPTH;
    q_occ[q]--;
    if (q_served[q] != 32'hFFFF_FFFF) q_served[q]++;
    num = longint'(q_served[q] - 1) * q_mean[q] + (longint'(dly) << 8);
    m = num / q_served[q];
    if (m > 64'hFF_FFFF) m = 64'hFF_FFFF;
    q_mean[q] = int'(m);
    return dly;
  endfunction

  function automatic void push_grant(int q, logic [15:0] dly, fsmw_pkg::phase_t ph);
    fsmw_pkg::out_t r;
    r.served_valid = 1'b1;
    r.queue_index = q[fsmw_pkg::QIDX_W-1:0];
    r.packet_delay = dly;
    r.phase = ph;
    r.last = 1'b0;
    grant_q.push_back(r);
  endfunction

  // Enqueue arrivals, then serve fair share and max weight; queue the grants.
  function automatic void predict_tick(fsmw_pkg::in_t req);
    int unsigned total, n, share, served, cap;
    int best, start;
    fsmw_pkg::out_t r;
    total = 0;
    served = 0;
    start = grant_q.size();
    for (int q = 0; q < NQ; q++) begin
      if (req.arrival_mask[q] && q_occ[q] < QDEPTH) begin
        arr_tick[q][(q_head[q] + q_occ[q]) % QDEPTH] = now_tick;
        q_occ[q]++;
      end
      total += q_occ[q];
    end
    cap = req.capacity;
    if (cap > MAXCAP) cap = MAXCAP;
    n = cap < total ? cap : total;
    share = n / NQ;
    for (int q = 0; q < NQ; q++) begin
      for (int j = 0; j < share && q_occ[q] != 0; j++) begin
        push_grant(q, serve_packet(q), fsmw_pkg::PH_FAIR);
        served++;
      end
    end
    while (served < n) begin
      best = 0;
      for (int q = 1; q < NQ; q++) begin
        if (q_occ[q] > q_occ[best] ||
            (q_occ[q] == q_occ[best] && q_mean[q] > q_mean[best]))
          best = q;
      end
      if (q_occ[best] == 0) break;
      push_grant(best, serve_packet(best), fsmw_pkg::PH_MAXW);
      served++;
    end
    if (grant_q.size() == start) begin
      r = '0;
      r.last = 1'b1;
      grant_q.push_back(r);
    end else begin
      grant_q[grant_q.size()-1].last = 1'b1;
    end
    now_tick++;
  endfunction

  // Offer one request; hold it until accepted, then update the prediction.
  task automatic send_tick(fsmw_pkg::in_t req, int gap, bit use_literal,
                           fsmw_pkg::out_t literal);
    int depth;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    depth = grant_q.size();
    predict_tick(req);
    if (use_literal) begin
      while (grant_q.size() > depth) void'(grant_q.pop_back());
      grant_q.push_back(literal);
    end
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Check accepted grants against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (grant_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected grant %p", out_data);
      end else begin
        fsmw_pkg::out_t e;
        e = grant_q.pop_front();
        if (out_data !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("grant mismatch: expected %p, got %p", e, out_data);
        end
      end
    end
  end

  // Receiver stall pattern with one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken  <= 1'b1;
      hold_cycles <= HOLD_LEN;
      out_stall   <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 7) < 2);
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIM) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  typedef struct {
    logic [fsmw_pkg::MASK_W-1:0] mask;
    logic [fsmw_pkg::CAPI_W-1:0] cap;
    bit                          idle;
  } tick_row_t;

  tick_row_t directed [16] = '{
    '{20'h00000,  6'd0, 1'b1},   // nothing queued, nothing served
    '{20'h00000, 6'd63, 1'b1},   // excess capacity, empty queues
    '{20'hFFFFF,  6'd0, 1'b1},   // arrivals only
    '{20'hFFFFF, 6'd20, 1'b0},   // one fair-share grant per queue
    '{20'hFFFFF, 6'd63, 1'b0},   // capacity clipped to the maximum
    '{20'h80000,  6'd1, 1'b0},
    '{20'h00001,  6'd5, 1'b0},
    '{20'hAAAAA, 6'd41, 1'b0},
    '{20'h55555,  6'd7, 1'b0},
    '{20'hFFFFF, 6'd60, 1'b0},
    '{20'h00000, 6'd60, 1'b0},
    '{20'h00000, 6'd60, 1'b0},
    '{20'h0000F,  6'd0, 1'b0},
    '{20'h0F000,  6'd2, 1'b0},
    '{20'h00000, 6'd40, 1'b0},
    '{20'h00000,  6'd0, 1'b0}
  };

  initial begin
    fsmw_pkg::in_t req;
    fsmw_pkg::out_t idle_grant;
    int burst;
    idle_grant = '0;
    idle_grant.last = 1'b1;
    now_tick = '0;
    for (int q = 0; q < NQ; q++) begin
      q_head[q] = 0; q_occ[q] = 0; q_served[q] = 0; q_mean[q] = 0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      req.arrival_mask = directed[i].mask;
      req.capacity = directed[i].cap;
      send_tick(req, $urandom_range(0, 2), directed[i].idle, idle_grant);
    end

    burst = 0;
    for (int i = 0; i < RAND_TICKS; i++) begin
      if (i == 150) hold_req = 1'b1;
      if (i == 300) begin
        // let every expected grant drain before going on
        @(negedge clk);
        in_valid <= 1'b0;
        wait (grant_q.size() == 0);
      end
      case ($urandom_range(0, 3))
        0: req.arrival_mask = fsmw_pkg::MASK_W'($urandom);
        1: req.arrival_mask = 20'h1 << $urandom_range(0, NQ - 1);
        2: req.arrival_mask = fsmw_pkg::MASK_W'($urandom & $urandom);
        default: req.arrival_mask = '0;
      endcase
      req.capacity = ($urandom_range(0, 9) == 0) ?
                     fsmw_pkg::CAPI_W'($urandom_range(20, 63)) :
                     fsmw_pkg::CAPI_W'($urandom_range(0, 10));
      if (burst == 0) burst = $urandom_range(1, 12);
      burst--;
      send_tick(req, (burst == 0) ? $urandom_range(1, 20) : 0, 1'b0, idle_grant);
    end

    // build deep queues, then serve them at full capacity
    req.arrival_mask = 20'hFFFFF;
    req.capacity = 6'd0;
    for (int i = 0; i < FILL_TICKS; i++) send_tick(req, 0, 1'b0, idle_grant);
    for (int i = 0; i < 4; i++) begin
      req.arrival_mask = fsmw_pkg::MASK_W'($urandom);
      req.capacity = 6'd63;
      send_tick(req, 0, 1'b0, idle_grant);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (grant_q.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && grant_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
src/fsmw_pkg.sv
src/fsmw_store.sv
src/fsmw_muldiv.sv
src/fair_share_max_weight_scheduler.sv
dv/tb_fair_share_max_weight_scheduler.sv
